// ----- hdl/assert_macros.svh -----
// Assertion helpers shared by the interval timer port model RTL.
// ASSERT_CLK expects signals named clk and rst_n in the enclosing module; ASSERT_CLK_ALWAYS only clk.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_CLK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hdl/itpm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpm_pkg
// Shared types and constants of the interval timer port model.
// ----------------------------------------------------------------------------
package itpm_pkg;

  localparam int unsigned NCHAN = 3;

  // Fake counter decrement per low-byte read.
  localparam logic [15:0] READ_STEP = 16'd10;

  // Reload count reported for a load value of zero.
  localparam logic [16:0] RELOAD_FULL = 17'h10000;

  // Port codes
  localparam logic [1:0] CMD_PORT = 2'd3;

  // Access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Channel access modes
  typedef enum logic [1:0] {
    MODE_LATCH  = 2'd0,
    MODE_LOW    = 2'd1,
    MODE_HIGH   = 2'd2,
    MODE_TOGGLE = 2'd3
  } mode_t;

  // Per-channel request, already qualified by the transfer and channel select
  typedef struct packed {
    logic       mode_wr;
    mode_t      mode;
    logic       data_wr;
    logic       data_rd;
    logic [7:0] wdata;
  } chan_req_t;

  // Per-channel response for the access in flight
  typedef struct packed {
    logic [7:0]  rdata;
    logic [16:0] reload_value;
  } chan_rsp_t;

endpackage

// ----- hdl/itpm_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpm_in_if / itpm_out_if
// Valid/ready channels for bus accesses and their results.
// ----------------------------------------------------------------------------
interface itpm_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [1:0] port;
  logic [7:0] write_data;

  modport source (output valid, opcode, port, write_data, input ready);
  modport sink   (input valid, opcode, port, write_data, output ready);
endinterface

interface itpm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        reload_strobe;
  logic [1:0]  reload_channel;
  logic [16:0] reload_value;

  modport source (output valid, read_data, reload_strobe, reload_channel, reload_value,
                  input ready);
  modport sink   (input valid, read_data, reload_strobe, reload_channel, reload_value,
                  output ready);
endinterface

// ----- hdl/itpm_chan.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itpm_chan
// One timer channel: access mode, byte flip-flop, load value and fake counter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itpm_chan (
  input  logic                clk,
  input  logic                rst_n,
  input  itpm_pkg::chan_req_t req,
  output itpm_pkg::chan_rsp_t rsp
);

  itpm_pkg::mode_t mode_r, mode_nxt;
  logic            flip_r, flip_nxt;
  logic [15:0]     load_r, load_nxt;
  logic [15:0]     cnt_r, cnt_nxt;
  logic            active_r, active_nxt;

  logic            pick_high;
  logic [15:0]     cnt_base;

  // High byte targeted: high mode, or toggle mode with the flip-flop set
  assign pick_high = (mode_r == itpm_pkg::MODE_HIGH) ||
                     ((mode_r == itpm_pkg::MODE_TOGGLE) && flip_r);

  // Reload from the load value once the counter would underflow
  assign cnt_base = (cnt_r < itpm_pkg::READ_STEP) ? load_r : cnt_r;

  // Next state
  always_comb begin
    mode_nxt   = mode_r;
    flip_nxt   = flip_r;
    load_nxt   = load_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    if (req.mode_wr) begin
      mode_nxt = req.mode;
      if (req.mode == itpm_pkg::MODE_TOGGLE) begin
        flip_nxt = 1'b0;
      end
    end
    if (req.data_wr) begin
      load_nxt   = pick_high ? {req.wdata, load_r[7:0]} : {load_r[15:8], req.wdata};
      active_nxt = 1'b1;
      if (mode_r == itpm_pkg::MODE_TOGGLE) begin
        flip_nxt = ~flip_r;
      end
    end
    if (req.data_rd) begin
      if ((mode_r == itpm_pkg::MODE_LATCH) || (mode_r == itpm_pkg::MODE_TOGGLE)) begin
        flip_nxt = ~flip_r;
      end
      if (!pick_high) begin
        cnt_nxt = cnt_base - itpm_pkg::READ_STEP;
      end
    end
  end

  // Response
  always_comb begin
    rsp.rdata        = pick_high ? cnt_r[15:8] : cnt_nxt[7:0];
    rsp.reload_value = (load_nxt == 16'd0) ? itpm_pkg::RELOAD_FULL : {1'b0, load_nxt};
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= itpm_pkg::MODE_LATCH;
      flip_r   <= 1'b0;
      load_r   <= 16'd0;
      cnt_r    <= 16'd0;
      active_r <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      flip_r   <= flip_nxt;
      load_r   <= load_nxt;
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
    end
  end

  // Checks
  `ASSERT_CLK(a_wr_sets_active, req.data_wr |=> active_r,
              "data write did not mark channel active")
  `ASSERT_CLK(a_toggle_clears_flip,
              req.mode_wr && (req.mode == itpm_pkg::MODE_TOGGLE) && !req.data_rd |=> !flip_r,
              "toggle mode select did not clear byte flip-flop")
  `ASSERT_CLK(a_high_read_keeps_cnt, req.data_rd && pick_high |=> $stable(cnt_r),
              "high byte read changed the counter")

endmodule

// ----- hdl/interval_timer_port_model.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_timer_port_model
// Bus port model of a three-channel interval timer.
// ----------------------------------------------------------------------------
// Each transfer on in_bus is one byte read or write to port 0..2 (channel
// data) or port 3 (mode command); each gives exactly one result on out_bus
// from the result register, which the transfer loads. A new access can be
// taken every cycle: in_bus.ready is low only while the result register holds
// a result that out_bus has not yet taken. The per-channel registers are
// updated in the same edge that takes the access, so back-to-back accesses to
// one channel see each other's effect.
`include "assert_macros.svh"

module interval_timer_port_model (
  input  logic       clk,
  input  logic       rst_n,
  itpm_in_if.sink    in_bus,
  itpm_out_if.source out_bus
);

  localparam int unsigned NCHAN = itpm_pkg::NCHAN;

  logic                in_xfer;
  logic                out_valid_r;
  logic [7:0]          read_data_r, read_data_nxt;
  logic                strobe_r, strobe_nxt;
  logic [1:0]          channel_r, channel_nxt;
  logic [16:0]         reload_r, reload_nxt;

  itpm_pkg::chan_req_t chan_req [NCHAN];
  itpm_pkg::chan_rsp_t chan_rsp [NCHAN];

  // Handshake: free when empty or when the held result is being taken
  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign in_xfer      = in_bus.valid && in_bus.ready;

  // Channel units
  for (genvar i = 0; i < NCHAN; i++) begin : g_chan
    always_comb begin
      chan_req[i].mode_wr = in_xfer && (in_bus.opcode == itpm_pkg::OP_WRITE) &&
                            (in_bus.port == itpm_pkg::CMD_PORT) &&
                            (in_bus.write_data[7:6] == 2'(i));
      chan_req[i].mode    = itpm_pkg::mode_t'(in_bus.write_data[5:4]);
      chan_req[i].data_wr = in_xfer && (in_bus.opcode == itpm_pkg::OP_WRITE) &&
                            (in_bus.port == 2'(i));
      chan_req[i].data_rd = in_xfer && (in_bus.opcode == itpm_pkg::OP_READ) &&
                            (in_bus.port == 2'(i));
      chan_req[i].wdata   = in_bus.write_data;
    end

    itpm_chan u_chan (
      .clk   (clk),
      .rst_n (rst_n),
      .req   (chan_req[i]),
      .rsp   (chan_rsp[i])
    );
  end

  // Result selection
  always_comb begin
    read_data_nxt = 8'd0;
    strobe_nxt    = 1'b0;
    channel_nxt   = 2'd0;
    reload_nxt    = 17'd0;
    unique case (in_bus.port)
      2'd0: begin
        read_data_nxt = chan_rsp[0].rdata;
        reload_nxt    = chan_rsp[0].reload_value;
      end
      2'd1: begin
        read_data_nxt = chan_rsp[1].rdata;
        reload_nxt    = chan_rsp[1].reload_value;
      end
      2'd2: begin
        read_data_nxt = chan_rsp[2].rdata;
        reload_nxt    = chan_rsp[2].reload_value;
      end
      default: begin
        read_data_nxt = 8'd0;
        reload_nxt    = 17'd0;
      end
    endcase
    if (in_bus.port == itpm_pkg::CMD_PORT) begin
      read_data_nxt = 8'd0;
      reload_nxt    = 17'd0;
    end else if (in_bus.opcode == itpm_pkg::OP_WRITE) begin
      read_data_nxt = 8'd0;
      strobe_nxt    = 1'b1;
      channel_nxt   = in_bus.port;
    end else begin
      reload_nxt = 17'd0;
    end
  end

  // Result register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      read_data_r <= read_data_nxt;
      strobe_r    <= strobe_nxt;
      channel_r   <= channel_nxt;
      reload_r    <= reload_nxt;
    end
  end

  assign out_bus.valid          = out_valid_r;
  assign out_bus.read_data      = read_data_r;
  assign out_bus.reload_strobe  = strobe_r;
  assign out_bus.reload_channel = channel_r;
  assign out_bus.reload_value   = reload_r;

  // Checks
  `ASSERT_CLK(a_strobe_value_nonzero, out_valid_r && strobe_r |-> reload_r != 17'd0,
              "reload strobe with zero reload value")
  `ASSERT_CLK(a_no_strobe_fields_zero,
              out_valid_r && !strobe_r |-> (reload_r == 17'd0) && (channel_r == 2'd0),
              "reload fields set without strobe")
  `ASSERT_CLK(a_cmd_port_quiet,
              in_xfer && (in_bus.port == itpm_pkg::CMD_PORT) |=>
                (read_data_r == 8'd0) && !strobe_r,
              "command port access produced data")
  `ASSERT_CLK_ALWAYS(a_reset_empty, !rst_n |=> !out_valid_r,
                     "result register valid after reset")

endmodule

// ----- verif/tb_interval_timer_port_model.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_interval_timer_port_model
// Self-checking bench for the interval timer port model. A short table of
// directed bus accesses is run first, then several hundred random accesses,
// mostly programming sequences (mode command, data writes, data reads) on one
// channel. Every access is predicted by a local copy of the channel state and
// each result transfer is checked field by field in order. The sender works
// in bursts and the receiver stalls on its own pattern, with one long
// hold-off so that the result register fills and the input stalls.
// ----------------------------------------------------------------------------
module tb_interval_timer_port_model;

  localparam int          CLK_PERIOD  = 10;
  localparam int          STALL_LIMIT = 1000;
  localparam int          N_DIRECTED  = 24;
  localparam int          N_RANDOM    = 530;
  localparam int          LONG_HOLD   = 80;
  localparam logic [1:0]  CHAN_NONE   = 2'd3;  // channel select that is ignored

  typedef struct packed {
    logic       opcode;
    logic [1:0] port;
    logic [7:0] wdata;
  } access_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        reload_strobe;
    logic [1:0]  reload_channel;
    logic [16:0] reload_value;
  } port_result_t;

  typedef struct packed {
    access_t      acc;
    logic         typed;  // 1: res is the expected result, 0: use predictor
    port_result_t res;
  } stim_row_t;

  localparam port_result_t NO_RESULT = '0;

  logic clk;
  logic rst_n;

  itpm_in_if  in_bus ();
  itpm_out_if out_bus ();

  interval_timer_port_model u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  // Local copy of the channel state
  itpm_pkg::mode_t chan_mode   [itpm_pkg::NCHAN];
  logic            chan_flip   [itpm_pkg::NCHAN];
  logic [15:0]     chan_load   [itpm_pkg::NCHAN];
  logic [15:0]     chan_count  [itpm_pkg::NCHAN];
  logic            chan_active [itpm_pkg::NCHAN];

  port_result_t pending_port_results[$];
  stim_row_t    directed_rows [N_DIRECTED];

  int mismatches   = 0;
  int results_seen = 0;
  int idle_cycles  = 0;
  int burst_left   = 0;
  bit hold_active  = 1'b0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------
  function automatic void clear_timer_state();
    for (int i = 0; i < itpm_pkg::NCHAN; i++) begin
      chan_mode[i]   = itpm_pkg::MODE_LATCH;
      chan_flip[i]   = 1'b0;
      chan_load[i]   = '0;
      chan_count[i]  = '0;
      chan_active[i] = 1'b0;
    end
  endfunction

  // Data access on this channel targets the high byte
  function automatic logic targets_high(logic [1:0] ch);
    return (chan_mode[ch] == itpm_pkg::MODE_HIGH) ||
           (chan_mode[ch] == itpm_pkg::MODE_TOGGLE && chan_flip[ch]);
  endfunction

  function automatic port_result_t apply_port_access(access_t a);
    port_result_t r;
    logic [1:0]   ch;
    logic         high;
    r = NO_RESULT;
    if (a.opcode == itpm_pkg::OP_WRITE) begin
      if (a.port == itpm_pkg::CMD_PORT) begin
        ch = a.wdata[7:6];
        if (ch != CHAN_NONE) begin
          chan_mode[ch] = itpm_pkg::mode_t'(a.wdata[5:4]);
          if (chan_mode[ch] == itpm_pkg::MODE_TOGGLE) chan_flip[ch] = 1'b0;
        end
      end else begin
        ch = a.port;
        if (targets_high(ch)) chan_load[ch][15:8] = a.wdata;
        else                  chan_load[ch][7:0]  = a.wdata;
        chan_active[ch] = 1'b1;
        if (chan_mode[ch] == itpm_pkg::MODE_TOGGLE) chan_flip[ch] = ~chan_flip[ch];
        r.reload_strobe  = 1'b1;
        r.reload_channel = ch;
        r.reload_value   = (chan_load[ch] == '0) ? itpm_pkg::RELOAD_FULL
                                                 : {1'b0, chan_load[ch]};
      end
    end else if (a.port != itpm_pkg::CMD_PORT) begin
      ch   = a.port;
      high = targets_high(ch);
      if (chan_mode[ch] == itpm_pkg::MODE_LATCH || chan_mode[ch] == itpm_pkg::MODE_TOGGLE)
        chan_flip[ch] = ~chan_flip[ch];
      if (!high) begin
        // fake counter reloads once it has run below one step
        if (chan_count[ch] < itpm_pkg::READ_STEP) chan_count[ch] = chan_load[ch];
        chan_count[ch] = chan_count[ch] - itpm_pkg::READ_STEP;
        r.read_data    = chan_count[ch][7:0];
      end else begin
        r.read_data = chan_count[ch][15:8];
      end
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] mode_cmd(logic [1:0] ch, itpm_pkg::mode_t m);
    return {ch, m, 4'h0};
  endfunction

  // Data bytes lean towards small counts so the fake counter reloads often
  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(0, 15));
      4:          return 8'h00;
      5:          return 8'hFF;
      default:    return 8'($urandom);
    endcase
  endfunction

  function automatic access_t random_access();
    access_t a;
    int      k;
    k = $urandom_range(0, 99);
    a.wdata = 8'($urandom);
    if (k < 20) begin
      a.opcode = itpm_pkg::OP_WRITE;
      a.port   = itpm_pkg::CMD_PORT;
    end else if (k < 60) begin
      a.opcode = itpm_pkg::OP_WRITE;
      a.port   = 2'($urandom_range(0, 2));
      a.wdata  = data_byte();
    end else if (k < 95) begin
      a.opcode = itpm_pkg::OP_READ;
      a.port   = 2'($urandom_range(0, 2));
    end else begin
      a.opcode = itpm_pkg::OP_READ;
      a.port   = itpm_pkg::CMD_PORT;
    end
    return a;
  endfunction

  // One access transfer; the sender idles between bursts unless a hold-off runs
  task automatic send_access(access_t a, logic typed, port_result_t typed_res);
    port_result_t predicted;
    if (burst_left == 0) begin
      if (!hold_active) begin
        repeat ($urandom_range(1, 8)) begin
          @(negedge clk);
          in_bus.valid      <= 1'b0;
          in_bus.opcode     <= 1'($urandom);
          in_bus.port       <= 2'($urandom);
          in_bus.write_data <= 8'($urandom);
        end
      end
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_bus.valid      <= 1'b1;
    in_bus.opcode     <= a.opcode;
    in_bus.port       <= a.port;
    in_bus.write_data <= a.wdata;
    do @(posedge clk); while (!in_bus.ready);
    predicted = apply_port_access(a);
    pending_port_results.push_back(typed ? typed_res : predicted);
  endtask

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    port_result_t exp_r;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      results_seen++;
      if (pending_port_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual read_data 0x%0h value 0x%0h",
                 $time, out_bus.read_data, out_bus.reload_value);
        mismatches++;
      end else begin
        exp_r = pending_port_results.pop_front();
        check_field("read_data", exp_r.read_data, out_bus.read_data);
        check_field("reload_strobe", exp_r.reload_strobe, out_bus.reload_strobe);
        check_field("reload_channel", exp_r.reload_channel, out_bus.reload_channel);
        check_field("reload_value", exp_r.reload_value, out_bus.reload_value);
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("tb: failure");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall patterns in segments, one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int  style;
    int  phase;
    bit  hold_done;
    phase     = 0;
    hold_done = 1'b0;
    out_bus.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!hold_done && results_seen >= 150) begin
        hold_active = 1'b1;
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_bus.ready <= 1'b0;
        end
        hold_active = 1'b0;
        hold_done   = 1'b1;
      end
      style = $urandom_range(0, 3);
      repeat ($urandom_range(10, 60)) begin
        @(negedge clk);
        case (style)
          0:       out_bus.ready <= 1'b1;
          1:       out_bus.ready <= 1'($urandom);
          2:       out_bus.ready <= ($urandom_range(0, 3) == 0);
          default: out_bus.ready <= (phase % 3 == 0);
        endcase
        phase++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    access_t         a;
    int              n_random;
    int              n_writes;
    int              n_reads;
    logic [1:0]      ch;
    itpm_pkg::mode_t m;

    rst_n             = 1'b0;
    in_bus.valid      = 1'b0;
    in_bus.opcode     = itpm_pkg::OP_READ;
    in_bus.port       = '0;
    in_bus.write_data = '0;
    clear_timer_state();

    // Directed accesses from the reset state
    directed_rows = '{
      // command port read changes nothing
      '{'{itpm_pkg::OP_READ,  itpm_pkg::CMD_PORT, 8'hFF}, 1'b1, NO_RESULT},
      // low byte read from a zero counter reloads 0 and wraps
      '{'{itpm_pkg::OP_READ,  2'd0, 8'h00}, 1'b1, '{8'hF6, 1'b0, 2'd0, 17'd0}},
      '{'{itpm_pkg::OP_READ,  2'd0, 8'h00}, 1'b0, NO_RESULT},
      // latch mode writes the low byte; zero load reports the full count
      '{'{itpm_pkg::OP_WRITE, 2'd0, 8'h00}, 1'b1,
        '{8'h00, 1'b1, 2'd0, itpm_pkg::RELOAD_FULL}},
      '{'{itpm_pkg::OP_WRITE, 2'd1, 8'hFF}, 1'b1, '{8'h00, 1'b1, 2'd1, 17'd255}},
      // channel three select is ignored
      '{'{itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT,
          mode_cmd(CHAN_NONE, itpm_pkg::MODE_TOGGLE)}, 1'b1, NO_RESULT},
      '{'{itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT,
          mode_cmd(2'd0, itpm_pkg::MODE_TOGGLE)}, 1'b1, NO_RESULT},
      // toggle mode: low then high byte, on writes and on reads
      '{'{itpm_pkg::OP_WRITE, 2'd0, 8'h34}, 1'b0, NO_RESULT},
      '{'{itpm_pkg::OP_WRITE, 2'd0, 8'h12}, 1'b0, NO_RESULT},
      '{'{itpm_pkg::OP_READ,  2'd0, 8'hFF}, 1'b0, NO_RESULT},
      '{'{itpm_pkg::OP_READ,  2'd0, 8'h00}, 1'b0, NO_RESULT},
      // high byte mode
      '{'{itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT,
          mode_cmd(2'd1, itpm_pkg::MODE_HIGH)}, 1'b1, NO_RESULT},
      '{'{itpm_pkg::OP_WRITE, 2'd1, 8'hAB}, 1'b0, NO_RESULT},
      '{'{itpm_pkg::OP_READ,  2'd1, 8'h00}, 1'b0, NO_RESULT},
      '{'{itpm_pkg::OP_READ,  2'd1, 8'hFF}, 1'b0, NO_RESULT},
      // low byte mode with a load below one step
      '{'{itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT,
          mode_cmd(2'd2, itpm_pkg::MODE_LOW)}, 1'b1, NO_RESULT},
      '{'{itpm_pkg::OP_WRITE, 2'd2, 8'h05}, 1'b0, NO_RESULT},
      '{'{itpm_pkg::OP_READ,  2'd2, 8'h00}, 1'b0, NO_RESULT},
      '{'{itpm_pkg::OP_READ,  2'd2, 8'h00}, 1'b0, NO_RESULT},
      '{'{itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT, 8'hFF}, 1'b1, NO_RESULT},
      '{'{itpm_pkg::OP_WRITE, 2'd1, 8'h00}, 1'b0, NO_RESULT},
      '{'{itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT,
          mode_cmd(2'd0, itpm_pkg::MODE_LATCH)}, 1'b1, NO_RESULT},
      '{'{itpm_pkg::OP_READ,  2'd0, 8'h00}, 1'b0, NO_RESULT},
      '{'{itpm_pkg::OP_WRITE, 2'd2, 8'hFF}, 1'b0, NO_RESULT}
    };

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      send_access(directed_rows[i].acc, directed_rows[i].typed, directed_rows[i].res);

    // Random part: programming sequences on one channel, plus loose accesses
    n_random = 0;
    while (n_random < N_RANDOM) begin
      if ($urandom_range(0, 9) < 4) begin
        ch = 2'($urandom_range(0, 2));
        m  = itpm_pkg::mode_t'($urandom_range(0, 3));
        a  = '{itpm_pkg::OP_WRITE, itpm_pkg::CMD_PORT,
               mode_cmd(ch, m) | 8'($urandom_range(0, 15))};
        send_access(a, 1'b0, NO_RESULT);
        n_writes = $urandom_range(1, 2);
        n_reads  = $urandom_range(1, 6);
        repeat (n_writes)
          send_access('{itpm_pkg::OP_WRITE, ch, data_byte()}, 1'b0, NO_RESULT);
        repeat (n_reads)
          send_access('{itpm_pkg::OP_READ, ch, 8'($urandom)}, 1'b0, NO_RESULT);
        n_random += 1 + n_writes + n_reads;
      end else begin
        send_access(random_access(), 1'b0, NO_RESULT);
        n_random++;
      end
    end

    @(negedge clk);
    in_bus.valid <= 1'b0;

    // Drain, then keep running to catch stray results
    while (pending_port_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && pending_port_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- interval_timer_port_model.f -----
+incdir+hdl
hdl/itpm_pkg.sv
hdl/itpm_if.sv
hdl/itpm_chan.sv
hdl/interval_timer_port_model.sv
verif/tb_interval_timer_port_model.sv
